/* design/gwcc_pkg.sv */
// Shared types, constants and register map for the grid window collision check.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gwcc_pkg;

  // Grid geometry limits
  localparam int unsigned GRID_DIM_LIMIT   = 511;   // 9-bit width/height registers top out here
  localparam int unsigned GRID_STORE_CELLS = 65536; // cells at or beyond this index read as free
  localparam int unsigned DEF_MAX_WIDTH    = 256;
  localparam int unsigned DEF_MAX_HEIGHT   = 256;

  // APB register file
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CELL_SIZE   = 3'd2,
    REG_GRID_WIDTH  = 3'd3,
    REG_GRID_HEIGHT = 3'd4,
    REG_RADIUS      = 3'd5
  } gwcc_reg_e;

  localparam logic signed [23:0] RST_ORIGIN_X    = 24'sd0;
  localparam logic signed [23:0] RST_ORIGIN_Y    = 24'sd0;
  localparam logic [15:0]        RST_CELL_SIZE   = 16'd13;
  localparam logic [8:0]         RST_GRID_WIDTH  = 9'd256;
  localparam logic [8:0]         RST_GRID_HEIGHT = 9'd256;
  localparam logic [3:0]         RST_RADIUS      = 4'd6;

  // Divider: 25-bit signed dividend, magnitude below 2^24
  localparam int unsigned DIV_STEPS = 24;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } gwcc_action_e;

  typedef struct packed {
    logic               action;
    logic [15:0]        cell_index;
    logic signed [7:0]  cell_occupancy;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } gwcc_in_t;

  typedef struct packed {
    logic collision;
    logic was_query;
  } gwcc_out_t;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [15:0]        cell_size;
    logic [8:0]         grid_width;
    logic [8:0]         grid_height;
    logic [3:0]         radius;
  } gwcc_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_DIVX,
    ST_DIVY,
    ST_BOUND,
    ST_BASE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } gwcc_state_e;

endpackage

`default_nettype wire

/* design/gwcc_regs.sv */
// APB configuration registers of the grid window collision check.
// Depends on gwcc_pkg for the register map, reset values and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module gwcc_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gwcc_pkg::APB_AW-1:0] paddr,
  input  wire logic [gwcc_pkg::APB_DW-1:0] pwdata,
  output logic      [gwcc_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output gwcc_pkg::gwcc_cfg_t              cfg_o
);
  import gwcc_pkg::*;

  gwcc_cfg_t  cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= RST_ORIGIN_X;
      cfg_q.origin_y     <= RST_ORIGIN_Y;
      cfg_q.cell_size    <= RST_CELL_SIZE;
      cfg_q.grid_width   <= RST_GRID_WIDTH;
      cfg_q.grid_height  <= RST_GRID_HEIGHT;
      cfg_q.radius       <= RST_RADIUS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_X:    cfg_q.origin_x     <= pwdata[23:0];
        REG_ORIGIN_Y:    cfg_q.origin_y     <= pwdata[23:0];
        REG_CELL_SIZE:   cfg_q.cell_size    <= pwdata[15:0];
        REG_GRID_WIDTH:  cfg_q.grid_width   <= pwdata[8:0];
        REG_GRID_HEIGHT: cfg_q.grid_height  <= pwdata[8:0];
        REG_RADIUS:      cfg_q.radius       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:    prdata = {8'd0, cfg_q.origin_x};
      REG_ORIGIN_Y:    prdata = {8'd0, cfg_q.origin_y};
      REG_CELL_SIZE:   prdata = {16'd0, cfg_q.cell_size};
      REG_GRID_WIDTH:  prdata = {23'd0, cfg_q.grid_width};
      REG_GRID_HEIGHT: prdata = {23'd0, cfg_q.grid_height};
      REG_RADIUS:      prdata = {28'd0, cfg_q.radius};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/gwcc_div.sv */
// Iterative signed divider: 25-bit dividend by 16-bit unsigned divisor, one
// quotient bit per cycle, truncating toward zero. Depends on gwcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwcc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [24:0] dividend_i,
  input  wire logic [15:0]        divisor_i,
  output logic                    done_o,
  output logic signed [24:0]      quotient_o
);
  import gwcc_pkg::*;

  localparam int unsigned CW = $clog2(DIV_STEPS + 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [23:0]   quo_q;
  logic [15:0]   rem_q;
  logic [15:0]   dsr_q;
  logic [24:0]   mag;
  logic [16:0]   trial;
  logic          fits;

  assign mag   = dividend_i[24] ? (25'd0 - dividend_i) : dividend_i;
  assign trial = {rem_q, quo_q[23]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring shift-subtract on the magnitude; sign applied at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[24];
      quo_q <= mag[23:0];
      rem_q <= '0;
      dsr_q <= (divisor_i == 16'd0) ? 16'd1 : divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
      quo_q <= {quo_q[22:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (25'sd0 - $signed({1'b0, quo_q})) : $signed({1'b0, quo_q});

endmodule

`default_nettype wire

/* design/gwcc_grid.sv */
// One-bit occupancy store with one write and one registered read port, plus
// the clearing pass after reset. Depends on gwcc_pkg for the wildcard import.
`timescale 1ns / 1ps
`default_nettype none

module gwcc_grid #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o,
  output logic               clr_busy_o
);
  import gwcc_pkg::*;

  logic          grid_q [DEPTH];
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;
  logic          rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Clearing pass owns the write port until it finishes
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      grid_q[clr_cnt_q] <= 1'b0;
    end else if (we_i) begin
      grid_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= grid_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

/* design/grid_window_collision_check_top.sv */
// Top level of the grid window collision check: sequencer, window scan and
// output register. Depends on gwcc_pkg, gwcc_regs, gwcc_div and gwcc_grid.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a one-bit occupancy grid and answers square-footprint
// collision queries. One transaction is handled at a time: in_ready_o is high
// only while the sequencer is idle. A cell write passes through the write state
// to the response state, where its acknowledgement is registered on the output;
// the sequencer returns to idle as it is loaded, so a new transaction is never
// taken before the last one is through. A query runs two 24-step divisions on
// the one shared divider, then reads the clipped window one cell per cycle from
// the single read port of the grid memory; its result is registered in the
// response state once the last read has drained, or once the window proves
// empty. Cells whose index lies at or beyond 65536 read as free. After reset
// the memory, min(MAX_WIDTH * MAX_HEIGHT, 65536) cells with each dimension
// first capped at 511 (65536 by default), is swept clear one cell per cycle;
// no transaction is accepted until that ends, while APB writes are taken at any
// time. A finished result waits in the output register until taken, and the
// following transaction cannot finish meanwhile.
module grid_window_collision_check_top #(
  parameter int unsigned MAX_WIDTH  = gwcc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = gwcc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire gwcc_pkg::gwcc_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output gwcc_pkg::gwcc_out_t              out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gwcc_pkg::APB_AW-1:0] paddr,
  input  wire logic [gwcc_pkg::APB_DW-1:0] pwdata,
  output logic      [gwcc_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  import gwcc_pkg::*;

  localparam int unsigned WMAX  = (MAX_WIDTH  > GRID_DIM_LIMIT) ? GRID_DIM_LIMIT : MAX_WIDTH;
  localparam int unsigned HMAX  = (MAX_HEIGHT > GRID_DIM_LIMIT) ? GRID_DIM_LIMIT : MAX_HEIGHT;
  localparam int unsigned DEPTH = (WMAX * HMAX > GRID_STORE_CELLS) ? GRID_STORE_CELLS
                                                                   : WMAX * HMAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gwcc_cfg_t   cfg;
  gwcc_state_e state_q, state_d;
  gwcc_in_t    item_q;

  // Effective grid size after clamping to the build limits
  logic [8:0]  eff_w, eff_h;
  logic [17:0] cells;

  // Divider
  logic               div_start, div_done;
  logic signed [24:0] div_dvd, div_quo;
  logic signed [24:0] gx_q, gy_q;

  // Window bounds and scan position
  logic signed [25:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [25:0] w_last, h_last;
  logic [8:0]         x0_d, y0_d, x0_q, y0_q;
  logic signed [9:0]  x1_d, y1_d, x1_q, y1_q;
  logic               win_empty;
  logic [8:0]         x_q, y_q;
  logic [17:0]        base_q;
  logic [17:0]        base_prod;
  logic [17:0]        scan_addr;
  logic               in_store;
  logic               row_end, col_end;

  // Grid memory ports
  logic          mem_we, mem_wdata, mem_re, mem_rdata, clr_busy;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          rd_vld_q, hit_q;

  // Output register
  logic      out_valid_q, out_load;
  gwcc_out_t out_q;
  logic      in_fire;

  gwcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gwcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cfg.cell_size),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  gwcc_grid #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .waddr_i    (mem_waddr),
    .wdata_i    (mem_wdata),
    .re_i       (mem_re),
    .raddr_i    (mem_raddr),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  assign eff_w = (cfg.grid_width  > 9'(WMAX)) ? 9'(WMAX) : cfg.grid_width;
  assign eff_h = (cfg.grid_height > 9'(HMAX)) ? 9'(HMAX) : cfg.grid_height;
  assign cells = eff_w * eff_h;

  assign in_ready_o = (state_q == ST_IDLE) && !clr_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  // Clip the square around (gx, gy); x0 saturates at 511 and x1 at -1 so
  // that out-of-grid windows still compare as empty in narrow registers.
  assign x_lo   = 26'(gx_q) - 26'(cfg.radius);
  assign x_hi   = 26'(gx_q) + 26'(cfg.radius);
  assign y_lo   = 26'(gy_q) - 26'(cfg.radius);
  assign y_hi   = 26'(gy_q) + 26'(cfg.radius);
  assign w_last = $signed({17'd0, eff_w}) - 26'sd1;
  assign h_last = $signed({17'd0, eff_h}) - 26'sd1;

  always_comb begin
    if (x_lo < 0)                 x0_d = 9'd0;
    else if (x_lo > 26'sd511)     x0_d = 9'd511;
    else                          x0_d = x_lo[8:0];
    if (y_lo < 0)                 y0_d = 9'd0;
    else if (y_lo > 26'sd511)     y0_d = 9'd511;
    else                          y0_d = y_lo[8:0];
    if (x_hi < 0)                 x1_d = -10'sd1;
    else if (x_hi > w_last)       x1_d = w_last[9:0];
    else                          x1_d = x_hi[9:0];
    if (y_hi < 0)                 y1_d = -10'sd1;
    else if (y_hi > h_last)       y1_d = h_last[9:0];
    else                          y1_d = y_hi[9:0];
  end

  assign win_empty = x1_q[9] || y1_q[9]
                  || (x0_q > x1_q[8:0]) || (y0_q > y1_q[8:0]);
  assign col_end   = (x_q == x1_q[8:0]);
  assign row_end   = (y_q == y1_q[8:0]);
  assign base_prod = y0_q * eff_w;
  assign scan_addr = base_q + 18'(x_q);
  assign in_store  = scan_addr < 18'(DEPTH);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.action == ACT_QUERY) ? ST_DIVX : ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_RESP;
      ST_DIVX:  if (div_done) state_d = ST_DIVY;
      ST_DIVY:  if (div_done) state_d = ST_BOUND;
      ST_BOUND: state_d = ST_BASE;
      ST_BASE:  state_d = win_empty ? ST_RESP : ST_SCAN;
      ST_SCAN:  if (col_end && row_end) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_RESP;
      ST_RESP:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {item_q.pos_y[23], item_q.pos_y} - {cfg.origin_y[23], cfg.origin_y};
    mem_we    = 1'b0;
    mem_waddr = item_q.cell_index[AW-1:0];
    mem_wdata = !item_q.cell_occupancy[7] && (item_q.cell_occupancy != 8'sd0);
    mem_re    = 1'b0;
    mem_raddr = scan_addr[AW-1:0];
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        div_start = in_fire && (in_data_i.action == ACT_QUERY);
        div_dvd   = {in_data_i.pos_x[23], in_data_i.pos_x} - {cfg.origin_x[23], cfg.origin_x};
      end
      ST_WRITE: mem_we    = {2'd0, item_q.cell_index} < cells;
      ST_DIVX:  div_start = div_done;
      // Cells beyond the store count as free: skip their read
      ST_SCAN:  mem_re    = in_store;
      ST_RESP:  out_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= mem_re;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_DIVX && div_done) begin
      gx_q <= div_quo;
    end
    if (state_q == ST_DIVY && div_done) begin
      gy_q <= div_quo;
    end
    if (state_q == ST_BOUND) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
    end
    case (state_q)
      ST_BASE: begin
        base_q <= base_prod;
        x_q    <= x0_q;
        y_q    <= y0_q;
      end
      ST_SCAN: begin
        if (col_end) begin
          x_q    <= x0_q;
          y_q    <= y_q + 9'd1;
          base_q <= base_q + 18'(eff_w);
        end else begin
          x_q <= x_q + 9'd1;
        end
      end
      default: ;
    endcase
    // Accumulate any occupied cell seen in the window
    if (state_q == ST_BOUND) begin
      hit_q <= 1'b0;
    end else if (rd_vld_q && mem_rdata) begin
      hit_q <= 1'b1;
    end
    if (out_load) begin
      out_q.was_query <= item_q.action;
      out_q.collision <= item_q.action && hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* design/gwcc_checker.sv */
// Port-level assertions for grid_window_collision_check_top and the bind that
// attaches them. Depends on gwcc_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module gwcc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire gwcc_pkg::gwcc_out_t         out_data_o
);
  import gwcc_pkg::*;

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // One transaction at a time: in_ready_o is held low after each acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("accepted a transaction while busy");

  // A write acknowledgement never reports a collision
  a_write_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.was_query |-> !out_data_o.collision)
    else $error("write acknowledgement carries a collision");

  // A new result is loaded as the sequencer returns to idle
  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared while sequencer busy");

endmodule

bind grid_window_collision_check_top gwcc_checker u_gwcc_checker (.*);

`default_nettype wire
